// ===== hdl/sru_pkg.sv =====
// Shared types and codes for the substring replace stream unit.
package sru_pkg;

    typedef logic [1:0] t_sel;

    localparam t_sel SEL_HEAD = 2'd0;
    localparam t_sel SEL_REP  = 2'd1;
    localparam t_sel SEL_BYTE = 2'd2;

    typedef logic [2:0] t_reg_idx;

    localparam t_reg_idx REG_PAT_BYTES = 3'd0;
    localparam t_reg_idx REG_PAT_LEN   = 3'd1;
    localparam t_reg_idx REG_REP_BYTES = 3'd2;
    localparam t_reg_idx REG_REP_LEN   = 3'd3;
    localparam t_reg_idx REG_MAX_REP   = 3'd4;

    typedef struct packed {
        logic [63:0] pattern_bytes;
        logic [3:0]  pattern_length;
        logic [63:0] replacement_bytes;
        logic [3:0]  replacement_length;
        logic [31:0] max_replacements;
    } t_cfg;

    typedef struct packed {
        logic load;
        logic emit;
        t_sel sel;
        logic pop;
        logic drop;
        logic append;
        logic rep_inc;
        logic rep_clr;
        logic done_inc;
        logic finish;
    } t_cmd;

    typedef struct packed {
        logic count_zero;
        logic full;
        logic below_plen;
        logic match;
        logic rep_end;
        logic can_replace;
        logic insert_mode;
        logic last;
        logic emit_ok;
    } t_status;

endpackage

// ===== hdl/sru_regs.sv =====
// APB-style configuration registers of the substring replace stream unit.
module sru_regs (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            psel,
    input  logic            penable,
    input  logic            pwrite,
    input  logic [5:0]      paddr,
    input  logic [63:0]     pwdata,
    output logic [63:0]     prdata,
    output logic            pready,
    output sru_pkg::t_cfg   o_cfg
);
    import sru_pkg::*;

    t_cfg r_cfg;
    logic w_wr;

    assign pready = 1'b1;
    assign w_wr   = psel && penable && pwrite;
    assign o_cfg  = r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.pattern_bytes      <= 64'd0;
            r_cfg.pattern_length     <= 4'd0;
            r_cfg.replacement_bytes  <= 64'd0;
            r_cfg.replacement_length <= 4'd0;
            r_cfg.max_replacements   <= 32'hFFFF_FFFF;
        end else if (w_wr) begin
            unique case (paddr[5:3])
                REG_PAT_BYTES: r_cfg.pattern_bytes      <= pwdata;
                REG_PAT_LEN:   r_cfg.pattern_length     <= pwdata[3:0];
                REG_REP_BYTES: r_cfg.replacement_bytes  <= pwdata;
                REG_REP_LEN:   r_cfg.replacement_length <= pwdata[3:0];
                REG_MAX_REP:   r_cfg.max_replacements   <= pwdata[31:0];
                default: begin
                end
            endcase
        end
    end

    always_comb begin
        unique case (paddr[5:3])
            REG_PAT_BYTES: prdata = r_cfg.pattern_bytes;
            REG_PAT_LEN:   prdata = 64'(r_cfg.pattern_length);
            REG_REP_BYTES: prdata = r_cfg.replacement_bytes;
            REG_REP_LEN:   prdata = 64'(r_cfg.replacement_length);
            REG_MAX_REP:   prdata = 64'(r_cfg.max_replacements);
            default:       prdata = 64'd0;
        endcase
    end

endmodule

// ===== hdl/sru_ctrl.sv =====
// Sequencing state machine of the substring replace stream unit.
module sru_ctrl (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  sru_pkg::t_status  i_status,
    output sru_pkg::t_cmd     o_cmd
);
    import sru_pkg::*;

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FLUSH  = 4'd1;
    localparam logic [3:0] S_REP1   = 4'd2;
    localparam logic [3:0] S_BYTE   = 4'd3;
    localparam logic [3:0] S_REP2   = 4'd4;
    localparam logic [3:0] S_PRE    = 4'd5;
    localparam logic [3:0] S_APPEND = 4'd6;
    localparam logic [3:0] S_DECIDE = 4'd7;
    localparam logic [3:0] S_MREP   = 4'd8;
    localparam logic [3:0] S_TAIL   = 4'd9;
    localparam logic [3:0] S_END    = 4'd10;

    logic [3:0] r_state;
    logic [3:0] n_state;
    t_cmd       w_cmd;

    assign o_in_ready = (r_state == S_IDLE);
    assign o_cmd      = w_cmd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state   = r_state;
        w_cmd     = '0;
        w_cmd.sel = SEL_HEAD;
        unique case (r_state) inside
            S_IDLE: begin
                if (i_in_valid) begin
                    w_cmd.load = 1'b1;
                    if (i_status.insert_mode) begin
                        if (!i_status.count_zero) begin
                            n_state = S_FLUSH;
                        end else if (i_status.can_replace) begin
                            n_state = S_REP1;
                        end else begin
                            n_state = S_BYTE;
                        end
                    end else if (!i_status.can_replace) begin
                        n_state = S_FLUSH;
                    end else if (i_status.full) begin
                        n_state = S_PRE;
                    end else begin
                        n_state = S_APPEND;
                    end
                end
            end
            S_FLUSH: begin
                if (i_status.count_zero) begin
                    n_state = S_BYTE;
                end else if (i_status.emit_ok) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.pop  = 1'b1;
                end
            end
            S_REP1, S_REP2: begin
                if (i_status.rep_end) begin
                    w_cmd.rep_clr  = 1'b1;
                    w_cmd.done_inc = 1'b1;
                    n_state = (r_state == S_REP1) ? S_BYTE : S_END;
                end else if (i_status.emit_ok) begin
                    w_cmd.emit    = 1'b1;
                    w_cmd.sel     = SEL_REP;
                    w_cmd.rep_inc = 1'b1;
                end
            end
            S_BYTE: begin
                if (i_status.emit_ok) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.sel  = SEL_BYTE;
                    if (i_status.insert_mode && i_status.last && i_status.can_replace) begin
                        n_state = S_REP2;
                    end else begin
                        n_state = S_END;
                    end
                end
            end
            S_PRE: begin
                if (i_status.emit_ok) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.pop  = 1'b1;
                    n_state    = S_APPEND;
                end
            end
            S_APPEND: begin
                w_cmd.append = 1'b1;
                n_state      = S_DECIDE;
            end
            S_DECIDE: begin
                if (i_status.below_plen) begin
                    n_state = i_status.last ? S_TAIL : S_END;
                end else if (i_status.match) begin
                    n_state = S_MREP;
                end else if (i_status.emit_ok) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.pop  = 1'b1;
                    n_state    = i_status.last ? S_TAIL : S_END;
                end
            end
            S_MREP: begin
                if (i_status.rep_end) begin
                    w_cmd.rep_clr  = 1'b1;
                    w_cmd.done_inc = 1'b1;
                    w_cmd.drop     = 1'b1;
                    n_state = i_status.last ? S_TAIL : S_END;
                end else if (i_status.emit_ok) begin
                    w_cmd.emit    = 1'b1;
                    w_cmd.sel     = SEL_REP;
                    w_cmd.rep_inc = 1'b1;
                end
            end
            S_TAIL: begin
                if (i_status.count_zero) begin
                    n_state = S_END;
                end else if (i_status.emit_ok) begin
                    w_cmd.emit = 1'b1;
                    w_cmd.pop  = 1'b1;
                end
            end
            S_END: begin
                if (i_status.emit_ok) begin
                    w_cmd.finish = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

// ===== hdl/sru_dp.sv =====
// Window, counters and output stages of the substring replace stream unit.
module sru_dp #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  sru_pkg::t_cfg     i_cfg,
    input  sru_pkg::t_cmd     i_cmd,
    output sru_pkg::t_status  o_status,
    input  logic [7:0]        i_data_byte,
    input  logic              i_last_byte,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [7:0]        o_out_byte,
    output logic              o_out_last
);
    import sru_pkg::*;

    localparam int CAP_P = (MAX_PATTERN < 8) ? MAX_PATTERN : 8;
    localparam int CAP_R = (MAX_REPLACEMENT < 8) ? MAX_REPLACEMENT : 8;
    localparam int CW    = $clog2(MAX_PATTERN + 1);
    localparam int IW    = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;

    logic [7:0]    r_win [MAX_PATTERN];
    logic [7:0]    n_win [MAX_PATTERN];
    logic [CW-1:0] r_count;
    logic [CW-1:0] n_count;
    logic [3:0]    r_rep_idx;
    logic [31:0]   r_done;
    logic [7:0]    r_byte;
    logic          r_last;
    logic          r_pend_valid;
    logic [7:0]    r_pend_byte;
    logic          r_out_valid;
    logic [7:0]    r_out_byte;
    logic          r_out_last;

    logic [3:0]    w_plen;
    logic [3:0]    w_rlen;
    logic [7:0]    w_cnt8;
    logic [7:0]    w_plen8;
    logic          w_match;
    logic          w_out_free;
    logic          w_push;
    logic [7:0]    w_emit_byte;
    logic          w_clear;

    assign w_plen  = (i_cfg.pattern_length > 4'(CAP_P)) ? 4'(CAP_P) : i_cfg.pattern_length;
    assign w_rlen  = (i_cfg.replacement_length > 4'(CAP_R)) ? 4'(CAP_R)
                                                            : i_cfg.replacement_length;
    assign w_cnt8  = 8'(r_count);
    assign w_plen8 = {4'd0, w_plen};

    always_comb begin
        w_match = 1'b1;
        for (int k = 0; k < CAP_P; k++) begin
            if ((8'(k) < w_plen8) && (r_win[k] != i_cfg.pattern_bytes[8*k +: 8])) begin
                w_match = 1'b0;
            end
        end
    end

    assign w_out_free = !r_out_valid || i_out_ready;
    assign w_push     = (i_cmd.emit || i_cmd.finish) && r_pend_valid;
    assign w_clear    = i_cmd.finish && r_last;

    always_comb begin
        case (i_cmd.sel)
            SEL_REP:  w_emit_byte = i_cfg.replacement_bytes[{r_rep_idx[2:0], 3'b000} +: 8];
            SEL_BYTE: w_emit_byte = r_byte;
            default:  w_emit_byte = r_win[0];
        endcase
    end

    assign o_status.count_zero  = (r_count == '0);
    assign o_status.full        = (w_cnt8 >= 8'(MAX_PATTERN));
    assign o_status.below_plen  = (w_cnt8 < w_plen8);
    assign o_status.match       = w_match;
    assign o_status.rep_end     = (r_rep_idx >= w_rlen);
    assign o_status.can_replace = (r_done < i_cfg.max_replacements);
    assign o_status.insert_mode = (w_plen == 4'd0);
    assign o_status.last        = r_last;
    assign o_status.emit_ok     = !r_pend_valid || w_out_free;

    always_comb begin
        n_win   = r_win;
        n_count = r_count;
        if (i_cmd.pop) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                if (i + 1 < MAX_PATTERN) begin
                    n_win[i] = r_win[i + 1];
                end
            end
            n_count = r_count - CW'(1);
        end else if (i_cmd.drop) begin
            for (int i = 0; i < MAX_PATTERN; i++) begin
                for (int s = 1; s <= CAP_P; s++) begin
                    if ((w_plen == 4'(s)) && (i + s < MAX_PATTERN)) begin
                        n_win[i] = r_win[i + s];
                    end
                end
            end
            n_count = (w_cnt8 > w_plen8) ? CW'(w_cnt8 - w_plen8) : '0;
        end else if (i_cmd.append) begin
            n_win[r_count[IW-1:0]] = r_byte;
            n_count = r_count + CW'(1);
        end
        if (w_clear) begin
            n_count = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        r_win <= n_win;
        if (i_cmd.load) begin
            r_byte <= i_data_byte;
        end
        if (i_cmd.emit) begin
            r_pend_byte <= w_emit_byte;
        end
        if (w_push) begin
            r_out_byte <= r_pend_byte;
            r_out_last <= i_cmd.finish && r_last;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count      <= '0;
            r_rep_idx    <= 4'd0;
            r_done       <= 32'd0;
            r_last       <= 1'b0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            r_count <= n_count;
            if (i_cmd.load) begin
                r_last <= i_last_byte;
            end
            if (i_cmd.rep_clr) begin
                r_rep_idx <= 4'd0;
            end else if (i_cmd.rep_inc) begin
                r_rep_idx <= r_rep_idx + 4'd1;
            end
            if (w_clear) begin
                r_done <= 32'd0;
            end else if (i_cmd.done_inc) begin
                r_done <= r_done + 32'd1;
            end
            if (i_cmd.emit) begin
                r_pend_valid <= 1'b1;
            end else if (i_cmd.finish) begin
                r_pend_valid <= 1'b0;
            end
            if (w_push) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_byte  = r_out_byte;
    assign o_out_last  = r_out_last;

endmodule

// ===== hdl/substring_replace_stream_unit.sv =====
// Top level of the substring replace stream unit.
// Each item is accepted in S_IDLE, then steps through states that append and compare a byte
// that joins the window, emit result bytes one at a time, close each replacement burst or
// window flush, and end in S_END; the next item is accepted only after S_END returns to idle.
// Result bytes pass a pending register to the output register; out_last rides on the final
// pending byte. Synchronous active-low reset clears counts and flags, loads register defaults.
module substring_replace_stream_unit #(
    parameter int MAX_PATTERN     = 8,
    parameter int MAX_REPLACEMENT = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_data_byte,
    input  logic        i_last_byte,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_out_byte,
    output logic        o_out_last,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [5:0]  paddr,
    input  logic [63:0] pwdata,
    output logic [63:0] prdata,
    output logic        pready
);
    import sru_pkg::*;

    t_cfg    w_cfg;
    t_cmd    w_cmd;
    t_status w_status;

    sru_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (w_cfg)
    );

    sru_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_status   (w_status),
        .o_cmd      (w_cmd)
    );

    sru_dp #(
        .MAX_PATTERN     (MAX_PATTERN),
        .MAX_REPLACEMENT (MAX_REPLACEMENT)
    ) u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg       (w_cfg),
        .i_cmd       (w_cmd),
        .o_status    (w_status),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last)
    );

endmodule

// ===== bench/tb.sv =====
// Self-checking bench for the substring replace stream unit.
`timescale 1ns / 1ps

module tb;
    import sru_pkg::*;

    typedef enum logic [0:0] {
        ROW_CFG  = 1'b0,
        ROW_ITEM = 1'b1
    } t_kind;

    typedef struct packed {
        logic [7:0] out_byte;
        logic       out_last;
    } t_out;

    typedef struct packed {
        t_kind       kind;
        t_reg_idx    reg_id;
        logic [63:0] value;
        logic [7:0]  d;
        logic        l;
        int          n_exp;
        logic [7:0]  e0;
        logic [7:0]  e1;
    } t_row;

    localparam int AUTO_EXP      = -1;
    localparam int SETTLE_CYCLES = 40;
    localparam int STEP_ITEMS    = 25;
    localparam int RANDOM_ITEMS  = 110;

    logic        i_clk;
    logic        i_rst_n;
    logic        i_in_valid;
    logic        o_in_ready;
    logic [7:0]  i_data_byte;
    logic        i_last_byte;
    logic        o_out_valid;
    logic        i_out_ready;
    logic [7:0]  o_out_byte;
    logic        o_out_last;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [5:0]  paddr;
    logic [63:0] pwdata;
    logic [63:0] prdata;
    logic        pready;

    substring_replace_stream_unit dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_ready  (o_in_ready),
        .i_data_byte (i_data_byte),
        .i_last_byte (i_last_byte),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_out_byte  (o_out_byte),
        .o_out_last  (o_out_last),
        .psel        (psel),
        .penable     (penable),
        .pwrite      (pwrite),
        .paddr       (paddr),
        .pwdata      (pwdata),
        .prdata      (prdata),
        .pready      (pready)
    );

    // shadow copy of the rewrite engine
    logic [63:0] pat_bytes = 64'd0;
    logic [3:0]  pat_len   = 4'd0;
    logic [63:0] rep_bytes = 64'd0;
    logic [3:0]  rep_len   = 4'd0;
    logic [31:0] max_rep   = 32'hFFFF_FFFF;
    logic [7:0]  held_win [0:7];
    int          held_n    = 0;
    logic [31:0] done_n    = 32'd0;

    t_out step_out[$];
    t_out expected_out[$];
    t_row plan[$];

    int   items_sent    = 0;
    int   bytes_checked = 0;
    int   setups_done   = 0;
    int   swaps_n       = 0;
    int   error_n       = 0;
    logic steady        = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    initial begin
        #20_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

    function automatic void flag_error(input string msg);
        error_n++;
        if (error_n <= 10) $display("%s", msg);
    endfunction

    function automatic int gap_len();
        int r;
        if (steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 65) return 0;
        if (r < 95) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic void put_out(input logic [7:0] b);
        t_out o;
        o.out_byte = b;
        o.out_last = 1'b0;
        step_out.push_back(o);
    endfunction

    function automatic void put_repl();
        int rlen;
        int k;
        rlen = (rep_len > 4'd8) ? 8 : int'(rep_len);
        for (k = 0; k < rlen; k++) put_out(rep_bytes[8*k +: 8]);
        done_n++;
        swaps_n++;
    endfunction

    function automatic void drop_held(input int n);
        int k;
        if (n >= held_n) begin
            held_n = 0;
        end else begin
            for (k = 0; k + n < 8; k++) held_win[k] = held_win[k + n];
            held_n = held_n - n;
        end
    endfunction

    function automatic void flush_held();
        int k;
        for (k = 0; k < held_n && k < 8; k++) put_out(held_win[k]);
        held_n = 0;
    endfunction

    function automatic void rewrite_byte(input logic [7:0] b, input logic l);
        int   plen;
        int   k;
        logic hit;
        logic had;
        t_out o;
        step_out.delete();
        plen = (pat_len > 4'd8) ? 8 : int'(pat_len);
        if (plen == 0) begin
            had = (held_n > 0);
            flush_held();
            if (!had && done_n < max_rep) put_repl();
            put_out(b);
            if (l && done_n < max_rep) put_repl();
        end else if (done_n >= max_rep) begin
            flush_held();
            put_out(b);
        end else begin
            if (held_n >= 8) begin
                put_out(held_win[0]);
                drop_held(1);
            end
            held_win[held_n] = b;
            held_n++;
            if (held_n >= plen) begin
                hit = 1'b1;
                for (k = 0; k < plen; k++) begin
                    if (held_win[k] != pat_bytes[8*k +: 8]) hit = 1'b0;
                end
                if (hit) begin
                    put_repl();
                    drop_held(plen);
                end else begin
                    put_out(held_win[0]);
                    drop_held(1);
                end
            end
            if (l) flush_held();
        end
        if (l) begin
            if (step_out.size() > 0) begin
                o = step_out.pop_back();
                o.out_last = 1'b1;
                step_out.push_back(o);
            end
            held_n = 0;
            done_n = 32'd0;
        end
    endfunction

    function automatic void tab_cfg(input t_reg_idx id, input logic [63:0] v);
        t_row r;
        r = '0;
        r.kind   = ROW_CFG;
        r.reg_id = id;
        r.value  = v;
        plan.push_back(r);
    endfunction

    function automatic void tab_item(input logic [7:0] d, input logic l, input int n,
                                     input logic [7:0] e0, input logic [7:0] e1);
        t_row r;
        r = '0;
        r.kind  = ROW_ITEM;
        r.d     = d;
        r.l     = l;
        r.n_exp = n;
        r.e0    = e0;
        r.e1    = e1;
        plan.push_back(r);
    endfunction

    task automatic send_item(input logic [7:0] d, input logic l, input int n_exp,
                             input logic [7:0] e0, input logic [7:0] e1);
        int   g;
        int   k;
        t_out o;
        g = gap_len();
        if (g > 0) begin
            i_in_valid <= 1'b0;
            repeat (g) @(posedge i_clk);
        end
        i_in_valid  <= 1'b1;
        i_data_byte <= d;
        i_last_byte <= l;
        @(posedge i_clk);
        while (!o_in_ready) @(posedge i_clk);
        rewrite_byte(d, l);
        if (n_exp == AUTO_EXP) begin
            foreach (step_out[k]) expected_out.push_back(step_out[k]);
        end else begin
            for (k = 0; k < n_exp; k++) begin
                o.out_byte = (k == 0) ? e0 : e1;
                o.out_last = l && (k == n_exp - 1);
                expected_out.push_back(o);
            end
        end
        items_sent++;
    endtask

    task automatic settle();
        i_in_valid <= 1'b0;
        while (expected_out.size() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);
    endtask

    task automatic write_reg(input t_reg_idx id, input logic [63:0] v);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {id, 3'b000};
        pwdata  <= v;
        @(posedge i_clk);
        penable <= 1'b1;
        @(posedge i_clk);
        while (!pready) @(posedge i_clk);
        case (id)
            REG_PAT_BYTES: pat_bytes = v;
            REG_PAT_LEN:   pat_len   = v[3:0];
            REG_REP_BYTES: rep_bytes = v;
            REG_REP_LEN:   rep_len   = v[3:0];
            REG_MAX_REP:   max_rep   = v[31:0];
            default: ;
        endcase
    endtask

    task automatic bus_idle();
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic run_phase(input logic final_phase);
        logic [7:0]  alpha [0:3];
        logic [63:0] pv;
        logic [63:0] rv;
        logic [31:0] mv;
        logic [7:0]  d;
        logic        drop_end;
        int          plen_v;
        int          rlen_v;
        int          plen_eff;
        int          nstr;
        int          slen;
        int          j;
        int          k;
        int          m;
        int          r;
        for (k = 0; k < 4; k++) alpha[k] = 8'($urandom);
        pv = 64'd0;
        for (k = 0; k < 8; k++) pv[8*k +: 8] = alpha[$urandom_range(0, 3)];
        if ($urandom_range(0, 4) == 0) pv = {$urandom, $urandom};
        r = $urandom_range(0, 19);
        plen_v = (r < 2) ? 0 : (r < 4) ? $urandom_range(9, 15) : $urandom_range(1, 8);
        rv = {$urandom, $urandom};
        rlen_v = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 15) : $urandom_range(0, 8);
        if ($urandom_range(0, 9) == 0) begin
            rv     = pv;
            rlen_v = plen_v;
        end
        r = $urandom_range(0, 9);
        mv = (r == 0) ? 32'd0 : (r == 1) ? 32'd1 : (r < 4) ? $urandom_range(2, 3) :
             (r < 6) ? $urandom : 32'hFFFF_FFFF;
        plen_eff = (plen_v > 8) ? 8 : plen_v;

        settle();
        steady = ($urandom_range(0, 3) == 0);
        write_reg(REG_PAT_BYTES, pv);
        write_reg(REG_PAT_LEN, 64'(plen_v));
        write_reg(REG_REP_BYTES, rv);
        write_reg(REG_REP_LEN, 64'(rlen_v));
        write_reg(REG_MAX_REP, {32'd0, mv});
        bus_idle();
        setups_done++;

        nstr = $urandom_range(2, 5);
        for (j = 0; j < nstr; j++) begin
            slen = $urandom_range(1, 16);
            drop_end = !final_phase && (j == nstr - 1) && ($urandom_range(0, 3) == 0);
            k = 0;
            while (k < slen) begin
                if (plen_eff > 0 && $urandom_range(0, 2) != 0) begin
                    for (m = 0; m < plen_eff && k < slen; m++) begin
                        d = pv[8*m +: 8];
                        if ($urandom_range(0, 9) == 0) d = 8'($urandom);
                        send_item(d, (k == slen - 1) && !drop_end, AUTO_EXP, 8'd0, 8'd0);
                        k++;
                    end
                end else begin
                    d = ($urandom_range(0, 3) == 0) ? 8'($urandom)
                                                     : alpha[$urandom_range(0, 3)];
                    send_item(d, (k == slen - 1) && !drop_end, AUTO_EXP, 8'd0, 8'd0);
                    k++;
                end
            end
        end
    endtask

    initial begin : out_side
        int stall_left;
        stall_left  = 0;
        i_out_ready = 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall_left > 0) begin
                stall_left--;
                i_out_ready <= 1'b0;
            end else begin
                i_out_ready <= 1'b1;
                stall_left = gap_len();
            end
        end
    end

    always @(posedge i_clk) begin : out_check
        t_out want;
        if (i_rst_n && o_out_valid && i_out_ready) begin
            bytes_checked++;
            if (expected_out.size() == 0) begin
                flag_error($sformatf("unexpected output: byte %02h last %0d",
                                     o_out_byte, o_out_last));
            end else begin
                want = expected_out.pop_front();
                if (o_out_byte !== want.out_byte || o_out_last !== want.out_last) begin
                    flag_error($sformatf(
                        "mismatch: expected byte %02h last %0d, got byte %02h last %0d",
                        want.out_byte, want.out_last, o_out_byte, o_out_last));
                end
            end
        end
    end

    initial begin : stim
        t_row row;
        int   i;
        i_rst_n     = 1'b0;
        i_in_valid  = 1'b0;
        i_data_byte = 8'd0;
        i_last_byte = 1'b0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = 6'd0;
        pwdata      = 64'd0;
        for (i = 0; i < 8; i++) held_win[i] = 8'd0;

        // reset values: empty pattern, empty replacement, no limit
        tab_item(8'h00, 1'b0, 1, 8'h00, 8'h00);
        tab_item(8'hFF, 1'b1, 1, 8'hFF, 8'h00);
        // limit of zero passes bytes through
        tab_cfg(REG_MAX_REP, 64'd0);
        tab_cfg(REG_PAT_BYTES, 64'h6261);
        tab_cfg(REG_PAT_LEN, 64'd2);
        tab_cfg(REG_REP_BYTES, 64'h5A5958);
        tab_cfg(REG_REP_LEN, 64'd3);
        tab_item(8'h61, 1'b0, 1, 8'h61, 8'h00);
        tab_item(8'h62, 1'b1, 1, 8'h62, 8'h00);
        tab_cfg(REG_MAX_REP, 64'hFFFF_FFFF);
        tab_item(8'h78, 1'b0, AUTO_EXP, 8'h00, 8'h00);
        tab_item(8'h61, 1'b0, AUTO_EXP, 8'h00, 8'h00);
        tab_item(8'h62, 1'b0, AUTO_EXP, 8'h00, 8'h00);
        tab_item(8'h79, 1'b1, AUTO_EXP, 8'h00, 8'h00);
        // limit reached after one replacement
        tab_cfg(REG_MAX_REP, 64'd1);
        tab_item(8'h61, 1'b0, AUTO_EXP, 8'h00, 8'h00);
        tab_item(8'h62, 1'b0, AUTO_EXP, 8'h00, 8'h00);
        tab_item(8'h61, 1'b0, AUTO_EXP, 8'h00, 8'h00);
        tab_item(8'h62, 1'b0, AUTO_EXP, 8'h00, 8'h00);
        tab_item(8'h80, 1'b1, AUTO_EXP, 8'h00, 8'h00);
        // lengths above range saturate to eight
        tab_cfg(REG_MAX_REP, 64'hFFFF_FFFF);
        tab_cfg(REG_PAT_BYTES, 64'hFFFF_FFFF_FFFF_FFFF);
        tab_cfg(REG_PAT_LEN, 64'd15);
        tab_cfg(REG_REP_BYTES, 64'd0);
        tab_cfg(REG_REP_LEN, 64'd15);
        for (i = 0; i < 8; i++) tab_item(8'hFF, i == 7, AUTO_EXP, 8'h00, 8'h00);
        // match on the final byte with an empty replacement
        tab_cfg(REG_PAT_BYTES, 64'd0);
        tab_cfg(REG_PAT_LEN, 64'd1);
        tab_cfg(REG_REP_LEN, 64'd0);
        tab_item(8'h00, 1'b1, AUTO_EXP, 8'h00, 8'h00);
        // switch to insertion mode with bytes held
        tab_cfg(REG_PAT_BYTES, 64'h636261);
        tab_cfg(REG_PAT_LEN, 64'd3);
        tab_cfg(REG_REP_BYTES, 64'h5150);
        tab_cfg(REG_REP_LEN, 64'd2);
        tab_item(8'h61, 1'b0, AUTO_EXP, 8'h00, 8'h00);
        tab_item(8'h62, 1'b0, AUTO_EXP, 8'h00, 8'h00);
        tab_cfg(REG_PAT_LEN, 64'd0);
        tab_item(8'h63, 1'b1, AUTO_EXP, 8'h00, 8'h00);

        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        i = 0;
        while (i < plan.size()) begin
            row = plan[i];
            if (row.kind == ROW_CFG) begin
                settle();
                while (i < plan.size() && plan[i].kind == ROW_CFG) begin
                    row = plan[i];
                    write_reg(row.reg_id, row.value);
                    i++;
                end
                bus_idle();
                setups_done++;
            end else begin
                send_item(row.d, row.l, row.n_exp, row.e0, row.e1);
                i++;
            end
        end

        while (items_sent < STEP_ITEMS + RANDOM_ITEMS)
            run_phase(items_sent >= STEP_ITEMS + RANDOM_ITEMS - 20);

        settle();
        $display("Sent %0d input items under %0d register setups, checked %0d output bytes.",
                 items_sent, setups_done, bytes_checked);
        $display("Covered %0d replacements with stalls and gaps on both sides.", swaps_n);
        if (error_n == 0) begin
            $display("RESULT: OK");
        end else begin
            $display("RESULT: ERROR");
        end
        $finish;
    end

endmodule
